[sv/rar_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rar_pkg;

  localparam int DEF_LOG_DEPTH = 64;
  localparam int DEF_ADDR_BITS = 48;

  // Field widths of the item channels, and the width used to widen addresses.
  localparam int KIND_W  = 2;
  localparam int FIELD_W = 48;
  localparam int LEN_W   = 32;
  localparam int WIDE_W  = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOG   = 2'd0,
    KIND_XLATE = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef struct packed {
    logic accept;
    logic clear_log;
    logic log_entry;
    logic calc_off;
    logic update;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[sv/rar_item_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rar_item_if;
  logic                        valid;
  logic                        ready;
  logic [rar_pkg::KIND_W-1:0]  kind;
  logic [rar_pkg::FIELD_W-1:0] address;
  logic [rar_pkg::FIELD_W-1:0] dest_address;
  logic [rar_pkg::LEN_W-1:0]   length;

  modport source (output valid, kind, address, dest_address, length, input ready);
  modport sink (input valid, kind, address, dest_address, length, output ready);
endinterface

`default_nettype wire

[sv/rar_result_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rar_result_if;
  logic                        valid;
  logic                        ready;
  logic [rar_pkg::FIELD_W-1:0] result_address;
  logic                        sheared;
  logic                        overflow;

  modport source (output valid, result_address, sheared, overflow, input ready);
  modport sink (input valid, result_address, sheared, overflow, output ready);
endinterface

`default_nettype wire

[sv/rar_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module rar_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           valid,
  input  rar_pkg::kind_t kind,
  output logic           ready,
  input  rar_pkg::sts_t  sts,
  output rar_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_WRITE  = 6'b000010,
    S_FETCH  = 6'b000100,
    S_OFFSET = 6'b001000,
    S_UPDATE = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (valid) begin
          cmd.accept = 1'b1;
          unique case (kind)
            rar_pkg::KIND_LOG: begin
              state_next = S_WRITE;
            end
            rar_pkg::KIND_XLATE: begin
              state_next = sts.empty ? S_FINISH : S_FETCH;
            end
            rar_pkg::KIND_CLEAR: begin
              cmd.clear_log = 1'b1;
              state_next    = S_FINISH;
            end
            default: begin
              state_next = S_FINISH;
            end
          endcase
        end
      end
      S_WRITE: begin
        cmd.log_entry = 1'b1;
        state_next    = S_FINISH;
      end
      // The log entry read is registered, so its data is first usable in OFFSET.
      S_FETCH: begin
        state_next = S_OFFSET;
      end
      S_OFFSET: begin
        cmd.calc_off = 1'b1;
        state_next   = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = sts.last ? S_FINISH : S_FETCH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/rar_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module rar_datapath #(
  parameter int LOG_DEPTH = rar_pkg::DEF_LOG_DEPTH,
  parameter int ADDR_BITS = rar_pkg::DEF_ADDR_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rar_pkg::cmd_t               cmd,
  output rar_pkg::sts_t               sts,
  input  rar_pkg::kind_t              kind,
  input  logic [rar_pkg::FIELD_W-1:0] address,
  input  logic [rar_pkg::FIELD_W-1:0] dest_address,
  input  logic [rar_pkg::LEN_W-1:0]   length,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rar_pkg::FIELD_W-1:0] result_address,
  output logic                        sheared,
  output logic                        overflow
);

  localparam int IDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W = $clog2(LOG_DEPTH + 1);
  localparam int LEN_W = rar_pkg::LEN_W;
  localparam int CMP_W = (ADDR_BITS > LEN_W) ? ADDR_BITS : LEN_W;

  logic [ADDR_BITS-1:0] src_mem [LOG_DEPTH];
  logic [ADDR_BITS-1:0] dst_mem [LOG_DEPTH];
  logic [LEN_W-1:0]     len_mem [LOG_DEPTH];

  logic [ADDR_BITS-1:0] rd_src;
  logic [ADDR_BITS-1:0] rd_dst;
  logic [LEN_W-1:0]     rd_len;

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     idx;
  logic [ADDR_BITS-1:0] cur_a;
  logic [ADDR_BITS-1:0] item_dest;
  logic [LEN_W-1:0]     item_len;
  logic [ADDR_BITS-1:0] off_r;
  logic                 shear_r;
  logic                 ovf_r;
  logic                 xlate_r;

  logic [rar_pkg::WIDE_W-1:0] addr_wide;
  logic [rar_pkg::WIDE_W-1:0] dest_wide;
  logic [rar_pkg::WIDE_W-1:0] res_wide;
  logic [CMP_W-1:0]           off_ext;
  logic [LEN_W-1:0]           remain;
  logic                       hit;
  logic                       full;
  logic [CNT_W:0]             idx_inc;

  assign addr_wide = rar_pkg::WIDE_W'(address);
  assign dest_wide = rar_pkg::WIDE_W'(dest_address);
  assign res_wide  = rar_pkg::WIDE_W'(cur_a);

  assign full    = (count == CNT_W'(LOG_DEPTH));
  assign idx_inc = {1'b0, idx} + (CNT_W + 1)'(1);

  assign sts.empty    = (count == '0);
  assign sts.last     = (idx_inc >= {1'b0, count});
  assign sts.out_free = !out_valid || out_ready;

  // Offset into the entry's source range; the range may wrap past the top of the space.
  assign off_ext = CMP_W'(off_r);
  assign hit     = off_ext < CMP_W'(rd_len);
  assign remain  = rd_len - off_ext[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.log_entry && !full) begin
      src_mem[count[IDX_W-1:0]] <= cur_a;
      dst_mem[count[IDX_W-1:0]] <= item_dest;
      len_mem[count[IDX_W-1:0]] <= item_len;
    end
    rd_src <= src_mem[idx[IDX_W-1:0]];
    rd_dst <= dst_mem[idx[IDX_W-1:0]];
    rd_len <= len_mem[idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      if (cmd.clear_log) begin
        count <= '0;
      end else if (cmd.log_entry && !full) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.accept) begin
        idx <= '0;
      end else if (cmd.update) begin
        idx <= idx_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_a     <= addr_wide[ADDR_BITS-1:0];
      item_dest <= dest_wide[ADDR_BITS-1:0];
      item_len  <= length;
      shear_r   <= 1'b0;
      ovf_r     <= 1'b0;
      xlate_r   <= (kind == rar_pkg::KIND_XLATE);
    end else begin
      if (cmd.log_entry && full) begin
        ovf_r <= 1'b1;
      end
      if (cmd.calc_off) begin
        off_r <= cur_a - rd_src;
      end
      if (cmd.update && hit) begin
        cur_a <= rd_dst + off_r;
        if (item_len > remain) begin
          shear_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result_address <= xlate_r ? res_wide[rar_pkg::FIELD_W-1:0] : '0;
      sheared        <= xlate_r && shear_r;
      overflow       <= ovf_r;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(LOG_DEPTH))
    else $error("log fill count exceeds the log depth");

  a_walk_in_log: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> (idx < count))
    else $error("translate walk reached past the last logged entry");

  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten before its item was taken");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_log |=> (count == '0))
    else $error("log not empty after a clear item");

endmodule

`default_nettype wire

[sv/relocation_address_remapper.sv]
// Items are taken one at a time, only while idle. A log item writes its entry and then loads
// its result; a clear or unused item loads its result directly. A translate item walks the
// logged entries in order (none when the log is empty), each entry passing through the
// fetch, offset and update steps on the single registered read port of the log memory.
// Reset clears the state machine, the log fill count and the result valid; the log
// memory itself is not cleared, and only entries below the fill count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module relocation_address_remapper #(
  parameter int LOG_DEPTH = rar_pkg::DEF_LOG_DEPTH,
  parameter int ADDR_BITS = rar_pkg::DEF_ADDR_BITS
) (
  input  logic         clk,
  input  logic         rst,
  rar_item_if.sink     items,
  rar_result_if.source results
);

  rar_pkg::cmd_t cmd;
  rar_pkg::sts_t sts;

  rar_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .valid (items.valid),
    .kind  (rar_pkg::kind_t'(items.kind)),
    .ready (items.ready),
    .sts   (sts),
    .cmd   (cmd)
  );

  rar_datapath #(
    .LOG_DEPTH (LOG_DEPTH),
    .ADDR_BITS (ADDR_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .kind           (rar_pkg::kind_t'(items.kind)),
    .address        (items.address),
    .dest_address   (items.dest_address),
    .length         (items.length),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .result_address (results.result_address),
    .sheared        (results.sheared),
    .overflow       (results.overflow)
  );

endmodule

`default_nettype wire

[tb/rar_remap_monitor.sv]
`timescale 1ns / 1ps

module rar_remap_monitor #(
  parameter int LOG_DEPTH = rar_pkg::DEF_LOG_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  rar_item_if         items,
  rar_result_if       results,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct packed {
    logic [rar_pkg::FIELD_W-1:0] address;
    logic                        sheared;
    logic                        overflow;
  } remap_result_t;

  logic [rar_pkg::FIELD_W-1:0] move_source [LOG_DEPTH];
  logic [rar_pkg::FIELD_W-1:0] move_dest   [LOG_DEPTH];
  logic [rar_pkg::LEN_W-1:0]   move_length [LOG_DEPTH];
  int unsigned                 move_count;
  remap_result_t               remap_expected_q[$];

  // Updates the move log and returns the result that the item should produce.
  function automatic remap_result_t remap_item(input logic [rar_pkg::KIND_W-1:0]  kind,
                                               input logic [rar_pkg::FIELD_W-1:0] addr,
                                               input logic [rar_pkg::FIELD_W-1:0] dest,
                                               input logic [rar_pkg::LEN_W-1:0]   len);
    remap_result_t               res;
    logic [rar_pkg::FIELD_W-1:0] cur;
    logic [rar_pkg::FIELD_W-1:0] offset;
    logic [rar_pkg::LEN_W-1:0]   room;
    int unsigned                 idx;
    res = '0;
    case (kind)
      rar_pkg::KIND_LOG: begin
        if (move_count < LOG_DEPTH) begin
          move_source[move_count] = addr;
          move_dest[move_count]   = dest;
          move_length[move_count] = len;
          move_count++;
        end else begin
          res.overflow = 1'b1;
        end
      end
      rar_pkg::KIND_XLATE: begin
        cur = addr;
        for (idx = 0; idx < move_count; idx++) begin
          // The offset wraps, so a source range may run past the top of memory.
          offset = cur - move_source[idx];
          if (offset < move_length[idx]) begin
            room = move_length[idx] - offset[rar_pkg::LEN_W-1:0];
            if (len > room) begin
              res.sheared = 1'b1;
            end
            cur = move_dest[idx] + offset;
          end
        end
        res.address = cur;
      end
      rar_pkg::KIND_CLEAR: begin
        move_count = 0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    remap_result_t got;
    remap_result_t want;
    remap_result_t pred;
    int unsigned   errs;
    errs = 0;
    if (rst) begin
      move_count = 0;
      remap_expected_q.delete();
      fail_count <= 0;
    end else begin
      // The result side goes first: its item is always older than a new input.
      if (results.valid && results.ready) begin
        got.address  = results.result_address;
        got.sheared  = results.sheared;
        got.overflow = results.overflow;
        if (remap_expected_q.size() == 0) begin
          $error("result item with none expected: result_address %h", got.address);
          errs++;
        end else begin
          want = remap_expected_q.pop_front();
          if (got.address !== want.address) begin
            $error("result_address mismatch: expected %h, actual %h",
                   want.address, got.address);
            errs++;
          end
          if (got.sheared !== want.sheared) begin
            $error("sheared mismatch: expected %b, actual %b", want.sheared, got.sheared);
            errs++;
          end
          if (got.overflow !== want.overflow) begin
            $error("overflow mismatch: expected %b, actual %b",
                   want.overflow, got.overflow);
            errs++;
          end
        end
      end
      if (items.valid && items.ready) begin
        pred = remap_item(items.kind, items.address, items.dest_address, items.length);
        remap_expected_q = {remap_expected_q, pred};
      end
      fail_count <= fail_count + errs;
    end
    pending <= remap_expected_q.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam logic [rar_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_CYCLES  = 250;
  localparam int unsigned PHASE_ITEMS   = 477;

  logic        clk;
  logic        rst;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_seq;
  int unsigned sent_count;

  rar_item_if   items_ch ();
  rar_result_if results_ch ();

  relocation_address_remapper dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  rar_remap_monitor u_monitor (
    .clk        (clk),
    .rst        (rst),
    .items      (items_ch),
    .results    (results_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin : watchdog
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    results_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [rar_pkg::FIELD_W-1:0] rand_addr();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[rar_pkg::FIELD_W-1:0];
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [rar_pkg::KIND_W-1:0]  kind,
                           input logic [rar_pkg::FIELD_W-1:0] addr,
                           input logic [rar_pkg::FIELD_W-1:0] dest,
                           input logic [rar_pkg::LEN_W-1:0]   len);
    while ($urandom_range(99) < send_idle_pct) begin
      items_ch.valid <= 1'b0;
      @(negedge clk);
    end
    items_ch.valid        <= 1'b1;
    items_ch.kind         <= kind;
    items_ch.address      <= addr;
    items_ch.dest_address <= dest;
    items_ch.length       <= len;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
    if (kind != KIND_UNUSED) begin
      sent_count++;
    end
    @(negedge clk);
  endtask

  // Mostly a clear, a run of moves and lookups aimed at the logged ranges;
  // sometimes a short burst of unrelated items.
  task automatic run_episode(input bit force_overflow);
    logic [rar_pkg::FIELD_W-1:0] ep_src[$];
    logic [rar_pkg::FIELD_W-1:0] ep_dst[$];
    logic [rar_pkg::LEN_W-1:0]   ep_len[$];
    logic [rar_pkg::FIELD_W-1:0] src;
    logic [rar_pkg::FIELD_W-1:0] dst;
    logic [rar_pkg::LEN_W-1:0]   len;
    logic [rar_pkg::LEN_W-1:0]   off;
    logic [rar_pkg::LEN_W-1:0]   size;
    int unsigned                 n_moves;
    int unsigned                 n_lookups;
    int unsigned                 pick;
    if (!force_overflow && $urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 6)) begin
        send_item(rar_pkg::KIND_W'($urandom_range(3)), rand_addr(), rand_addr(), $urandom);
      end
      return;
    end
    send_item(rar_pkg::KIND_CLEAR, rand_addr(), rand_addr(), $urandom);
    if (force_overflow) begin
      // More moves than the log holds, so the last ones are dropped.
      n_moves = $urandom_range(66, 70);
    end else if ($urandom_range(7) == 0) begin
      n_moves = $urandom_range(60, 70);
    end else begin
      n_moves = $urandom_range(0, 12);
    end
    repeat (n_moves) begin
      case ($urandom_range(5))
        0, 1: begin
          // Chain onto an earlier destination so that a lookup can hit twice.
          if (ep_src.size() != 0) begin
            pick = $urandom_range(ep_src.size() - 1);
            src  = ep_dst[pick];
            if (ep_len[pick] != 0) begin
              src = src + $urandom_range(ep_len[pick] - 1);
            end
          end else begin
            src = rand_addr();
          end
        end
        2: src = {rar_pkg::FIELD_W{1'b1}} - $urandom_range(255);
        default: src = rand_addr();
      endcase
      case ($urandom_range(9))
        0: len = '0;
        1: len = {rar_pkg::LEN_W{1'b1}};
        2, 3: len = $urandom;
        default: len = $urandom_range(1, 4096);
      endcase
      dst = ($urandom_range(7) == 0) ? {rar_pkg::FIELD_W{1'b1}} - $urandom_range(255)
                                     : rand_addr();
      send_item(rar_pkg::KIND_LOG, src, dst, len);
      ep_src = {ep_src, src};
      ep_dst = {ep_dst, dst};
      ep_len = {ep_len, len};
    end
    n_lookups = $urandom_range(1, 8);
    repeat (n_lookups) begin
      if (ep_src.size() == 0 || $urandom_range(9) == 0) begin
        send_item(rar_pkg::KIND_XLATE, rand_addr(), rand_addr(), $urandom);
      end else begin
        pick = $urandom_range(ep_src.size() - 1);
        len  = ep_len[pick];
        off  = '0;
        if (len != 0) begin
          case ($urandom_range(3))
            0: off = len - 1;
            1: off = '0;
            default: off = $urandom_range(len - 1);
          endcase
        end
        case ($urandom_range(7))
          0: size = '0;
          1: size = {rar_pkg::LEN_W{1'b1}};
          2: size = len - off;
          3: size = len - off + 1;
          default: size = $urandom_range(64);
        endcase
        send_item(rar_pkg::KIND_XLATE, ep_src[pick] + off, rand_addr(), size);
      end
    end
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned target;
    bit          first_episode;
    rst                   = 1'b1;
    items_ch.valid        = 1'b0;
    items_ch.kind         = rar_pkg::KIND_CLEAR;
    items_ch.address      = '0;
    items_ch.dest_address = '0;
    items_ch.length       = '0;
    send_idle_pct         = 16;
    recv_idle_pct         = 60;
    hold_seq              = 0;
    sent_count            = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_item(rar_pkg::KIND_XLATE, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_item(KIND_UNUSED, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_item(rar_pkg::KIND_CLEAR, 48'h0, 48'h0, 32'h0);
    // This source range wraps past the top of the address space.
    send_item(rar_pkg::KIND_LOG, 48'hFFFF_FFFF_FFF0, 48'h0000_0000_1000, 32'h20);
    send_item(rar_pkg::KIND_LOG, 48'h0, 48'hFFFF_FFFF_FFFF, 32'h0);
    send_item(rar_pkg::KIND_LOG, 48'h0000_0000_1000, 48'h8000_0000_0000, 32'h100);
    send_item(rar_pkg::KIND_XLATE, 48'hFFFF_FFFF_FFF8, 48'h0, 32'h8);
    send_item(rar_pkg::KIND_XLATE, 48'h0000_0000_0008, 48'h0, 32'h30);
    send_item(rar_pkg::KIND_XLATE, 48'h0000_0000_000F, 48'h0, 32'h0);
    send_item(rar_pkg::KIND_XLATE, 48'h0000_0000_000F, 48'h0, 32'h1);
    send_item(rar_pkg::KIND_XLATE, 48'h0000_0000_000F, 48'h0, 32'h2);
    send_item(rar_pkg::KIND_XLATE, 48'h0, 48'h0, 32'h0);
    send_item(rar_pkg::KIND_XLATE, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 32'hFFFF_FFFF);
    send_item(rar_pkg::KIND_LOG, 48'h0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_item(rar_pkg::KIND_XLATE, 48'h0000_FFFF_FFFE, 48'h0, 32'h4);
    send_item(rar_pkg::KIND_CLEAR, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_item(rar_pkg::KIND_XLATE, 48'h0000_0000_1008, 48'h0, 32'h10);

    first_episode = 1'b1;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 16; recv_idle_pct = 60; end
        1: begin send_idle_pct = 60; recv_idle_pct = 16; hold_seq++; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      target = sent_count + PHASE_ITEMS;
      while (sent_count < target) begin
        run_episode(first_episode);
        first_episode = 1'b0;
      end
    end
    items_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
